// File: hw/rtl/uae_pkg.sv
package uae_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_BAUD_DIVISOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SPEED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RX_PIN_IS_INPUT = 2'd2;

	// Receive status register bits
	localparam int STATUS_SPEN_BIT = 7;
	localparam int STATUS_CREN_BIT = 4;

	// Baud counter width; (255+1)*160 fits
	localparam int BAUD_W = 16;

	// Transmit pending count: minus one, zero, one
	typedef enum logic [1:0] {
		PEND_NONE = 2'b11,
		PEND_ZERO = 2'b00,
		PEND_ONE  = 2'b01
	} tx_pend_t;

	// Receive FIFO fill level
	typedef enum logic [1:0] {
		FILL_EMPTY = 2'd0,
		FILL_ONE   = 2'd1,
		FILL_TWO   = 2'd2
	} rx_fill_t;

	// One instruction cycle
	typedef struct packed {
		logic       write_tx;
		logic       write_status;
		logic       read_rx;
		logic [7:0] bus_data;
		logic       rx_valid;
		logic [7:0] rx_byte;
	} step_t;

	// Result of one instruction cycle
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_taken;
		logic [7:0] rx_data;
		logic       rx_flag;
		logic       tx_flag;
		logic       shift_empty;
		logic       overrun;
	} result_t;

endpackage

// File: hw/rtl/uae_chan_if.sv
interface uae_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/usart_async_emulation_core.sv
// Asynchronous USART model, one item per emulated instruction cycle.
// Channels: step (sink) carries bus strobes, bus data and an offered line
// byte; result (source) carries the line transmit byte, whether the line
// byte was taken, the receive data register and the status flags.
// Configuration: cfg_we/cfg_index/cfg_wdata write baud_divisor (0),
// high_speed (1) and rx_pin_is_input (2); write only while idle.
// Path: an accepted item passes the input register, then a single-pass
// update into the result register.
// Throughput: one item per cycle unless result stalls; set by the state update loop.
// The next item is taken while a finished result still waits.
// Stall: when result.ready is low with a result held, the input register
// holds its item and step.ready drops once it is also full; nothing is
// lost or repeated.
// Reset: all flags, FIFO, transmit path and the baud counter clear, the
// transmit pending count goes to none, rx_pin_is_input resets to 1.
module usart_async_emulation_core
	import uae_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	uae_chan_if.sink             step,
	uae_chan_if.source           result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// configuration
	logic [7:0] baud_div_q;
	logic       high_speed_q;
	logic       rx_pin_in_q;

	// architectural state
	logic             port_en_q, cont_rx_q, active_q, over_q, empty_q;
	logic             tx_irq_q, rx_irq_q;
	logic [7:0]       tx_hold_q, tx_shift_q, rx_first_q, rx_second_q;
	tx_pend_t         pend_q;
	rx_fill_t         fill_q;
	logic [BAUD_W-1:0] baud_q;

	// next state
	logic             port_en_n, cont_rx_n, active_n, over_n, empty_n;
	logic             tx_irq_n, rx_irq_n;
	logic [7:0]       tx_hold_n, tx_shift_n, rx_first_n, rx_second_n;
	tx_pend_t         pend_n;
	rx_fill_t         fill_n;
	logic [BAUD_W-1:0] baud_n;
	logic             sent, taken;
	logic [7:0]       sent_byte;

	// pipeline
	logic    s1_valid;
	step_t   item_s1;
	logic    res_valid_q;
	result_t res_q;
	logic    advance;

	logic [8:0]        div_p1;
	logic [BAUD_W-1:0] limit;

	assign advance = s1_valid && (!res_valid_q || result.ready);
	assign step.ready = !s1_valid || advance;
	assign result.valid = res_valid_q;
	assign result.payload = res_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baud_div_q <= '0;
			high_speed_q <= 1'b0;
			rx_pin_in_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BAUD_DIVISOR:    baud_div_q <= cfg_wdata;
				CFG_HIGH_SPEED:      high_speed_q <= cfg_wdata[0];
				CFG_RX_PIN_IS_INPUT: rx_pin_in_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// byte period: (divisor+1) * 40 or * 160, as shifts and one add
	assign div_p1 = {1'b0, baud_div_q} + 9'd1;
	always_comb begin
		if (high_speed_q)
			limit = BAUD_W'({div_p1, 5'b0}) + BAUD_W'({div_p1, 3'b0});
		else
			limit = BAUD_W'({div_p1, 7'b0}) + BAUD_W'({div_p1, 5'b0});
	end

	// one instruction cycle of the USART
	always_comb begin
		port_en_n = port_en_q;
		cont_rx_n = cont_rx_q;
		active_n = active_q;
		over_n = over_q;
		empty_n = empty_q;
		tx_irq_n = tx_irq_q;
		rx_irq_n = rx_irq_q;
		tx_hold_n = tx_hold_q;
		tx_shift_n = tx_shift_q;
		rx_first_n = rx_first_q;
		rx_second_n = rx_second_q;
		pend_n = pend_q;
		fill_n = fill_q;
		baud_n = baud_q;
		sent = 1'b0;
		sent_byte = '0;
		taken = 1'b0;

		// transmit register write
		if (item_s1.write_tx) begin
			case (pend_n)
				PEND_NONE: pend_n = PEND_ZERO;
				default:   pend_n = PEND_ONE;
			endcase
			if (pend_n == PEND_ZERO)
				tx_shift_n = item_s1.bus_data;
			tx_hold_n = item_s1.bus_data;
			empty_n = 1'b0;
			tx_irq_n = 1'b0;
		end

		// status register write
		if (item_s1.write_status) begin
			port_en_n = item_s1.bus_data[STATUS_SPEN_BIT];
			cont_rx_n = item_s1.bus_data[STATUS_CREN_BIT];
			if (!cont_rx_n) begin
				over_n = 1'b0;
				baud_n = '0;
			end
		end

		// receive register read pops the FIFO
		if (item_s1.read_rx) begin
			case (fill_n)
				FILL_ONE: begin
					rx_first_n = '0;
					rx_irq_n = 1'b0;
					fill_n = FILL_EMPTY;
				end
				FILL_TWO: begin
					rx_first_n = rx_second_n;
					rx_second_n = '0;
					fill_n = FILL_ONE;
				end
				default: ;
			endcase
		end

		if (port_en_n) begin
			// activation
			if (!active_n) begin
				active_n = 1'b1;
				empty_n = 1'b1;
				tx_irq_n = 1'b1;
				pend_n = PEND_NONE;
			end
			// shift register load
			if (empty_n && pend_n != PEND_NONE) begin
				case (pend_n)
					PEND_ONE: pend_n = PEND_ZERO;
					default:  pend_n = PEND_NONE;
				endcase
				if (pend_n == PEND_ZERO) begin
					tx_shift_n = tx_hold_n;
					empty_n = 1'b0;
					tx_irq_n = 1'b0;
				end
			end
			// baud tick
			baud_n = baud_n + BAUD_W'(1);
			if (baud_n >= limit) begin
				baud_n = '0;
				if (rx_pin_in_q && item_s1.rx_valid) begin
					taken = 1'b1;
					if (cont_rx_n && !over_n) begin
						case (fill_n)
							FILL_EMPTY: begin
								rx_first_n = item_s1.rx_byte;
								rx_second_n = '0;
								fill_n = FILL_ONE;
							end
							FILL_ONE: begin
								rx_second_n = item_s1.rx_byte;
								fill_n = FILL_TWO;
							end
							default: over_n = 1'b1;
						endcase
					end
					rx_irq_n = 1'b1;
				end
				if (!empty_n) begin
					sent = 1'b1;
					sent_byte = tx_shift_n;
					empty_n = 1'b1;
					tx_irq_n = 1'b1;
				end
			end
		end else begin
			active_n = 1'b0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (step.ready) begin
			s1_valid <= step.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step.ready && step.valid)
			item_s1 <= step.payload;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.tx_valid <= sent;
			res_q.tx_byte <= sent_byte;
			res_q.rx_taken <= taken;
			res_q.rx_data <= rx_first_n;
			res_q.rx_flag <= rx_irq_n;
			res_q.tx_flag <= tx_irq_n;
			res_q.shift_empty <= empty_n;
			res_q.overrun <= over_n;
		end
	end

	// architectural state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_en_q <= 1'b0;
			cont_rx_q <= 1'b0;
			active_q <= 1'b0;
			over_q <= 1'b0;
			empty_q <= 1'b0;
			tx_irq_q <= 1'b0;
			rx_irq_q <= 1'b0;
			tx_hold_q <= '0;
			tx_shift_q <= '0;
			rx_first_q <= '0;
			rx_second_q <= '0;
			pend_q <= PEND_NONE;
			fill_q <= FILL_EMPTY;
			baud_q <= '0;
		end else if (advance) begin
			port_en_q <= port_en_n;
			cont_rx_q <= cont_rx_n;
			active_q <= active_n;
			over_q <= over_n;
			empty_q <= empty_n;
			tx_irq_q <= tx_irq_n;
			rx_irq_q <= rx_irq_n;
			tx_hold_q <= tx_hold_n;
			tx_shift_q <= tx_shift_n;
			rx_first_q <= rx_first_n;
			rx_second_q <= rx_second_n;
			pend_q <= pend_n;
			fill_q <= fill_n;
			baud_q <= baud_n;
		end
	end

endmodule
